// ----- design/irtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irtd_pkg: shared types and constants of the inquiry RSSI target detector
// Holds the request modes, register indexes, parser phases, the result
// record and the character helpers used by the line parser.
// ----------------------------------------------------------------------------
package irtd_pkg;

   localparam int TARGET_SLOTS_DEF = 5;
   localparam int TARGET_SLOTS_MAX = 5;

   localparam int ADDR_W      = 48;
   localparam int SLOT_CNT_W  = 3;
   localparam int RSSI_W      = 8;
   localparam int TICK_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int DIGIT_CNT_W = 4;

   localparam logic [DIGIT_CNT_W-1:0] ADDR_DIGITS     = 4'd12;
   localparam logic [DIGIT_CNT_W-1:0] ADDR_DIGITS_CAP = 4'd13;

   // Request modes.
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_BYTE  = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_A         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGETS_IN_USE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SIGNAL_THRESHOLD = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SCAN_LENGTH      = 3'd7;

   localparam logic [SLOT_CNT_W-1:0] TARGETS_IN_USE_RST   = 3'd5;
   localparam logic [RSSI_W-1:0]     SIGNAL_THRESHOLD_RST = 8'd128;
   localparam logic [TICK_W-1:0]     SCAN_LENGTH_RST      = 16'd10;

   // Characters of interest.
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_Q     = 8'h51;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [RSSI_W-1:0] RSSI_MAX = 8'hFF;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_COLON = 3'd1,
      PH_ADDR  = 3'd2,
      PH_CLASS = 3'd3,
      PH_SKIP  = 3'd4,
      PH_RSSI  = 3'd5
   } phase_type;

   typedef struct packed {
      logic              event_res;
      logic              address_match;
      logic [RSSI_W-1:0] rssi;
      logic              target_found;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0:    c = CH_PLUS;
         2'd1:    c = CH_I;
         2'd2:    c = CH_N;
         default: c = CH_Q;
      endcase
      return c;
   endfunction

endpackage

// ----- design/inquiry_rssi_target_detector.sv -----
`timescale 1ns / 1ps
// A result is registered into the output register, or into the skid register while the output is held.
// Throughput: one request per cycle while req_stall is low; parsing and all address compares are combinational.
// A two-entry result queue (output register and skid register) keeps accepting
// while one result waits; req_stall rises only when both entries are full.
// Reset (synchronous, active high) restores register defaults, idles the scan
// and sends the parser hunting for the next line prefix.
// ----------------------------------------------------------------------------
// inquiry_rssi_target_detector
// Parses "+INQ:addr,class,rssi" lines from a byte stream, matches the address
// against configured targets and reports RSSI, match and scan timeouts.
// ----------------------------------------------------------------------------
module inquiry_rssi_target_detector
   import irtd_pkg::*;
#(
   parameter int TARGET_SLOTS = TARGET_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [7:0]            req_data_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_event_res,
   output logic                  rsp_address_match,
   output logic [RSSI_W-1:0]     rsp_rssi,
   output logic                  rsp_target_found,

   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // Configuration registers.
   logic [ADDR_W-1:0]     target_ff [TARGET_SLOTS];
   logic [SLOT_CNT_W-1:0] targets_in_use_ff;
   logic [RSSI_W-1:0]     threshold_ff;
   logic [TICK_W-1:0]     scan_length_ff;

   // Parser and scan state.
   phase_type              phase_ff, phase_in;
   logic [1:0]             prefix_ff, prefix_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   well_formed_ff, well_formed_in;
   logic [DIGIT_CNT_W-1:0] digit_cnt_ff, digit_cnt_in;
   logic                   skip_ff, skip_in;
   logic [RSSI_W-1:0]      rssi_ff, rssi_in;
   logic [TICK_W-1:0]      elapsed_ff, elapsed_in;
   logic                   active_ff, active_in;
   logic                   line_match_ff, line_match_in;

   // Result queue.
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic                  accept;
   logic                  take;
   logic                  res_valid;
   result_type            res;
   hex_type               hex;
   logic                  addr_hit;
   logic [SLOT_CNT_W-1:0] slots_used;
   logic [TICK_W-1:0]     elapsed_inc;
   logic                  found;

   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_res     = out_ff.event_res;
   assign rsp_address_match = out_ff.address_match;
   assign rsp_rssi          = out_ff.rssi;
   assign rsp_target_found  = out_ff.target_found;

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TARGET_SLOTS; i++) begin
            target_ff[i] <= '0;
         end
         targets_in_use_ff <= TARGETS_IN_USE_RST;
         threshold_ff      <= SIGNAL_THRESHOLD_RST;
         scan_length_ff    <= SCAN_LENGTH_RST;
      end else if (csr_write_enable) begin
         for (int i = 0; i < TARGET_SLOTS; i++) begin
            if (csr_index == REG_TARGET_A + CSR_IDX_W'(i)) begin
               target_ff[i] <= csr_write_data[ADDR_W-1:0];
            end
         end
         case (csr_index)
            REG_TARGETS_IN_USE:   targets_in_use_ff <= csr_write_data[SLOT_CNT_W-1:0];
            REG_SIGNAL_THRESHOLD: threshold_ff      <= csr_write_data[RSSI_W-1:0];
            REG_SCAN_LENGTH:      scan_length_ff    <= csr_write_data[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Address compare against the enabled targets
   // ------------------------------------------------------------------------
   always_comb begin
      slots_used = (targets_in_use_ff > SLOT_CNT_W'(TARGET_SLOTS)) ?
                   SLOT_CNT_W'(TARGET_SLOTS) : targets_in_use_ff;
      addr_hit = 1'b0;
      for (int i = 0; i < TARGET_SLOTS; i++) begin
         if (SLOT_CNT_W'(i) < slots_used && target_ff[i] == addr_ff) begin
            addr_hit = 1'b1;
         end
      end
      if (!well_formed_ff || digit_cnt_ff != ADDR_DIGITS) begin
         addr_hit = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Request processing
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in       = phase_ff;
      prefix_in      = prefix_ff;
      addr_in        = addr_ff;
      well_formed_in = well_formed_ff;
      digit_cnt_in   = digit_cnt_ff;
      skip_in        = skip_ff;
      rssi_in        = rssi_ff;
      elapsed_in     = elapsed_ff;
      active_in      = active_ff;
      line_match_in  = line_match_ff;
      res_valid      = 1'b0;
      res            = '0;
      hex            = hex_decode(req_data_byte);
      elapsed_inc    = elapsed_ff + TICK_W'(1);
      found          = active_ff && line_match_ff && rssi_ff != '0 && rssi_ff > threshold_ff;

      if (accept) begin
         case (req_mode)
            MODE_START: begin
               phase_in       = PH_HUNT;
               prefix_in      = '0;
               addr_in        = '0;
               well_formed_in = 1'b1;
               digit_cnt_in   = '0;
               skip_in        = 1'b0;
               rssi_in        = '0;
               line_match_in  = 1'b0;
               elapsed_in     = '0;
               if (scan_length_ff == '0) begin
                  active_in     = 1'b0;
                  res_valid     = 1'b1;
                  res.event_res = 1'b1;
               end else begin
                  active_in = 1'b1;
               end
            end
            MODE_TICK: begin
               if (active_ff) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= scan_length_ff) begin
                     active_in     = 1'b0;
                     res_valid     = 1'b1;
                     res.event_res = 1'b1;
                  end
               end
            end
            MODE_BYTE: begin
               // A line feed outside the prefix hunt and the RSSI field drops the line.
               if (req_data_byte == CH_LF && phase_ff != PH_HUNT && phase_ff != PH_RSSI) begin
                  phase_in       = PH_HUNT;
                  prefix_in      = '0;
                  addr_in        = '0;
                  well_formed_in = 1'b1;
                  digit_cnt_in   = '0;
                  skip_in        = 1'b0;
                  rssi_in        = '0;
                  line_match_in  = 1'b0;
               end else begin
                  unique case (phase_ff)
                     PH_HUNT: begin
                        if (req_data_byte == prefix_char(prefix_ff)) begin
                           if (prefix_ff == 2'd3) begin
                              prefix_in = '0;
                              phase_in  = PH_COLON;
                           end else begin
                              prefix_in = prefix_ff + 2'd1;
                           end
                        end else begin
                           prefix_in = (req_data_byte == CH_PLUS) ? 2'd1 : 2'd0;
                        end
                     end
                     PH_COLON: begin
                        if (req_data_byte == CH_COLON) begin
                           addr_in        = '0;
                           well_formed_in = 1'b1;
                           digit_cnt_in   = '0;
                           phase_in       = PH_ADDR;
                        end
                     end
                     PH_ADDR: begin
                        if (req_data_byte == CH_COMMA) begin
                           line_match_in = addr_hit;
                           phase_in      = PH_CLASS;
                        end else if (hex.valid) begin
                           addr_in = {addr_ff[ADDR_W-5:0], hex.value};
                           if (digit_cnt_ff < ADDR_DIGITS_CAP) begin
                              digit_cnt_in = digit_cnt_ff + DIGIT_CNT_W'(1);
                           end
                        end else if (req_data_byte != CH_COLON) begin
                           well_formed_in = 1'b0;
                        end
                     end
                     PH_CLASS: begin
                        if (req_data_byte == CH_COMMA) begin
                           skip_in  = 1'b0;
                           phase_in = PH_SKIP;
                        end
                     end
                     PH_SKIP: begin
                        if (skip_ff) begin
                           skip_in  = 1'b0;
                           rssi_in  = '0;
                           phase_in = PH_RSSI;
                        end else begin
                           skip_in = 1'b1;
                        end
                     end
                     PH_RSSI: begin
                        if (hex.valid) begin
                           // Saturate once a nonzero high nibble would shift out.
                           rssi_in = (rssi_ff[7:4] != 4'd0) ? RSSI_MAX :
                                     {rssi_ff[3:0], hex.value};
                        end else begin
                           res_valid         = 1'b1;
                           res.address_match = line_match_ff;
                           res.rssi          = rssi_ff;
                           res.target_found  = found;
                           if (found) begin
                              active_in = 1'b0;
                           end
                           phase_in       = PH_HUNT;
                           prefix_in      = '0;
                           addr_in        = '0;
                           well_formed_in = 1'b1;
                           digit_cnt_in   = '0;
                           skip_in        = 1'b0;
                           rssi_in        = '0;
                           line_match_in  = 1'b0;
                        end
                     end
                     default: begin
                        phase_in       = PH_HUNT;
                        prefix_in      = '0;
                        addr_in        = '0;
                        well_formed_in = 1'b1;
                        digit_cnt_in   = '0;
                        skip_in        = 1'b0;
                        rssi_in        = '0;
                        line_match_in  = 1'b0;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Result queue: the skid register fills only while the output is held.
   // ------------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = accept && res_valid;
            skid_in       = res;
         end else begin
            out_valid_in = accept && res_valid;
            out_in       = res;
         end
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         prefix_ff      <= '0;
         addr_ff        <= '0;
         well_formed_ff <= 1'b1;
         digit_cnt_ff   <= '0;
         skip_ff        <= 1'b0;
         rssi_ff        <= '0;
         elapsed_ff     <= '0;
         active_ff      <= 1'b0;
         line_match_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         prefix_ff      <= prefix_in;
         addr_ff        <= addr_in;
         well_formed_ff <= well_formed_in;
         digit_cnt_ff   <= digit_cnt_in;
         skip_ff        <= skip_in;
         rssi_ff        <= rssi_in;
         elapsed_ff     <= elapsed_in;
         active_ff      <= active_in;
         line_match_ff  <= line_match_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTH
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_timeout_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res |->
         !rsp_address_match && rsp_rssi == '0 && !rsp_target_found)
      else $error("timeout result carries line fields");

   a_found_needs_match : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target_found |-> rsp_address_match && rsp_rssi != '0)
      else $error("target found without a matching address and nonzero rssi");

   a_found_ends_scan : assert property (@(posedge clock) disable iff (reset)
      accept && res_valid && res.target_found |=> !active_ff)
      else $error("scan still active after a found target");

   a_digit_cap : assert property (@(posedge clock) disable iff (reset)
      digit_cnt_ff <= ADDR_DIGITS_CAP)
      else $error("address digit count beyond its cap");
`endif

endmodule
